@@ rtl/mggb_pkg.sv @@
// shared types, constants and helpers for the masked gaussian grid blur
// no dependencies; imported by every module of the block

package mggb_pkg;

	// default storage and kernel limits
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_MAX_RADIUS = 4;

	// field and register widths
	localparam int COORD_W     = 8;
	localparam int SIZE_W      = 9;
	localparam int RADIUS_W    = 3;
	localparam int WEIGHT_W    = 17;
	localparam int CELL_W      = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 17;
	localparam int NUM_WEIGHTS = 5;
	localparam int WIDX_W      = 3;
	localparam int DIST_W      = 4;
	localparam int FRAC_W      = 16;
	// signed window coordinate: covers row plus or minus the largest radius
	localparam int CRD_W       = 10;

	typedef logic [WEIGHT_W-1:0] weight_t;

	localparam weight_t ONE_Q16 = 17'h10000;

	// operation codes
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_RADIUS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CENTER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ONE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_TWO    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_THREE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FOUR   = 3'd7;

	// unknown cell marker, also the result for an empty sum
	localparam logic signed [CELL_W-1:0] CELL_UNKNOWN = -8'sd1;

	// register reset values
	localparam logic [SIZE_W-1:0]   WIDTH_RESET  = 9'd256;
	localparam logic [SIZE_W-1:0]   HEIGHT_RESET = 9'd256;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 3'd2;
	localparam weight_t [NUM_WEIGHTS-1:0] WEIGHT_RESET =
		{17'd8869, 17'd21280, 17'd39750, 17'd57835, 17'd65536};

	// controller to datapath commands
	typedef struct packed {
		logic load_wr;
		logic start;
		logic step;
		logic div_start;
		logic out_load;
	} mggb_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic item_outside;
		logic walk_last;
		logic pipe_busy;
		logic div_done;
	} mggb_stat_t;

	// one-dimensional weight at a distance, zero beyond the table, capped at one
	function automatic weight_t weight_at(input weight_t [NUM_WEIGHTS-1:0] w,
		input logic [DIST_W-1:0] d);
		weight_t v;
		v = '0;
		if (d < DIST_W'(NUM_WEIGHTS)) begin
			v = w[d[WIDX_W-1:0]];
			if (v > ONE_Q16) begin
				v = ONE_Q16;
			end
		end
		return v;
	endfunction

endpackage

@@ rtl/mggb_ctrl.sv @@
// controller state machine for the masked gaussian grid blur
// depends on mggb_pkg; drives the datapath through mggb_cmd_t commands

module mggb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                operation,
	input  logic                out_stall,
	input  mggb_pkg::mggb_stat_t stat,
	output logic                in_stall,
	output logic                out_valid,
	output mggb_pkg::mggb_cmd_t  cmd
);
	import mggb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	// commands decoded from state
	always_comb begin
		accept        = in_valid && (state_q == ST_IDLE);
		cmd           = '0;
		cmd.load_wr   = accept && (operation == OP_LOAD);
		cmd.start     = accept && (operation == OP_COMPUTE);
		cmd.step      = (state_q == ST_WALK);
		cmd.div_start = (state_q == ST_DRAIN) && !stat.pipe_busy;
		cmd.out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// state and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= stat.item_outside ? ST_DONE : ST_WALK;
					end
				end
				ST_WALK: begin
					if (stat.walk_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!stat.pipe_busy) begin
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					if (stat.div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/mggb_dp.sv @@
// datapath of the masked gaussian grid blur: grid memory, window walk,
// weight and product pipeline, accumulators, restoring divider, result register
// depends on mggb_pkg; commanded by mggb_ctrl

module mggb_dp #(
	parameter int MAX_WIDTH  = mggb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mggb_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = mggb_pkg::DEF_MAX_RADIUS
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  mggb_pkg::mggb_cmd_t                              cmd,
	output mggb_pkg::mggb_stat_t                             stat,
	input  logic [mggb_pkg::COORD_W-1:0]                     row,
	input  logic [mggb_pkg::COORD_W-1:0]                     col,
	input  logic signed [mggb_pkg::CELL_W-1:0]               cell_value,
	input  logic [mggb_pkg::SIZE_W-1:0]                      map_width,
	input  logic [mggb_pkg::SIZE_W-1:0]                      map_height,
	input  logic [mggb_pkg::RADIUS_W-1:0]                    kernel_radius,
	input  mggb_pkg::weight_t [mggb_pkg::NUM_WEIGHTS-1:0]    weights,
	output logic signed [mggb_pkg::CELL_W-1:0]               blurred_value
);
	import mggb_pkg::*;

	localparam int CB      = $clog2(MAX_WIDTH);
	localparam int RB      = $clog2(MAX_HEIGHT);
	localparam int ADDR_W  = CB + RB;
	localparam int DEPTH   = MAX_HEIGHT * (2 ** CB);
	localparam int OFS_W   = $clog2(MAX_RADIUS + 1) + 1;
	localparam int CELLS   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int SUMW_W  = WEIGHT_W + $clog2(CELLS);
	localparam int SUMV_W  = SUMW_W + CELL_W;
	localparam int PROD_W  = CELL_W + WEIGHT_W + 1;
	// quotient magnitude never exceeds 128, so nine quotient bits suffice
	localparam int QB      = 9;
	localparam int CNT_W   = $clog2(QB + 1);
	localparam int DIV_W   = SUMW_W + QB;
	localparam int WCAP    = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
	localparam int HCAP    = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
	localparam logic signed [OFS_W-1:0] OFS_ONE = 1;

	// grid storage
	logic signed [CELL_W-1:0] mem [DEPTH];

	// map extents and radius in use
	logic [SIZE_W-1:0]          w_eff, h_eff;
	logic [DIST_W-1:0]          rad_cap;
	logic signed [OFS_W-1:0]    r_pos, r_neg;

	// item and walk registers
	logic [COORD_W-1:0]         row_q, col_q;
	logic                       outside_q;
	logic signed [OFS_W-1:0]    dm_q, dn_q;
	logic signed [CRD_W-1:0]    rr, cc;
	logic                       win_hit;
	logic [ADDR_W-1:0]          rd_addr, wr_addr;
	logic [DIST_W-1:0]          dm_abs, dn_abs;
	weight_t                    wa, wb;
	logic [2*WEIGHT_W-1:0]      wprod;

	// pipeline
	logic                       v_s1, v_s2;
	logic signed [CELL_W-1:0]   cell_s1;
	weight_t                    wt_s1, wt_s2;
	logic signed [PROD_W-1:0]   prod_c, prod_s2;

	// accumulators
	logic signed [SUMV_W-1:0]   sum_v_q, abs_v;
	logic [SUMW_W-1:0]          sum_w_q;

	// divider
	logic [DIV_W-1:0]           rem_q, den_sh;
	logic [SUMW_W-1:0]          den_q;
	logic [QB-1:0]              quo_q;
	logic                       neg_q;
	logic [CNT_W-1:0]           div_cnt_q, k;
	logic                       ge;
	logic signed [QB:0]         quo_s;
	logic signed [CELL_W-1:0]   result, blurred_q;

	// extents capped to storage
	assign w_eff   = (map_width > SIZE_W'(WCAP)) ? SIZE_W'(WCAP) : map_width;
	assign h_eff   = (map_height > SIZE_W'(HCAP)) ? SIZE_W'(HCAP) : map_height;
	assign rad_cap = ({1'b0, kernel_radius} > DIST_W'(MAX_RADIUS)) ?
		DIST_W'(MAX_RADIUS) : {1'b0, kernel_radius};
	assign r_pos   = $signed(OFS_W'(rad_cap));
	assign r_neg   = -r_pos;

	// incoming item position check
	assign stat.item_outside = ({1'b0, row} >= h_eff) || ({1'b0, col} >= w_eff);
	assign wr_addr = {RB'(row), CB'(col)};

	// window cell position
	assign rr      = $signed({2'b00, row_q}) + CRD_W'(dm_q);
	assign cc      = $signed({2'b00, col_q}) + CRD_W'(dn_q);
	assign win_hit = !rr[CRD_W-1] && !cc[CRD_W-1] &&
		(rr[SIZE_W-1:0] < h_eff) && (cc[SIZE_W-1:0] < w_eff);
	assign rd_addr = {RB'(rr[SIZE_W-1:0]), CB'(cc[SIZE_W-1:0])};

	// two-dimensional weight of the current offset
	assign dm_abs  = dm_q[OFS_W-1] ? DIST_W'(-dm_q) : DIST_W'(dm_q);
	assign dn_abs  = dn_q[OFS_W-1] ? DIST_W'(-dn_q) : DIST_W'(dn_q);
	assign wa      = weight_at(weights, dm_abs);
	assign wb      = weight_at(weights, dn_abs);
	assign wprod   = wa * wb;

	assign stat.walk_last = (dm_q == r_pos) && (dn_q == r_pos);
	assign stat.pipe_busy = v_s1 || v_s2;
	assign stat.div_done  = (div_cnt_q == '0);

	// grid memory: load writes, walk reads
	always_ff @(posedge clk) begin
		if (cmd.load_wr && !stat.item_outside) begin
			mem[wr_addr] <= cell_value;
		end
		if (cmd.step && win_hit) begin
			cell_s1 <= mem[rd_addr];
		end
	end

	// item capture and window offset counters
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			row_q     <= row;
			col_q     <= col;
			outside_q <= stat.item_outside;
			dm_q      <= r_neg;
			dn_q      <= r_neg;
		end else if (cmd.step) begin
			if (dn_q == r_pos) begin
				dn_q <= r_neg;
				dm_q <= dm_q + OFS_ONE;
			end else begin
				dn_q <= dn_q + OFS_ONE;
			end
		end
	end

	// product stage payload
	assign prod_c = cell_s1 * $signed({1'b0, wt_s1});

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			wt_s1 <= wprod[FRAC_W+WEIGHT_W-1:FRAC_W];
		end
		prod_s2 <= prod_c;
		wt_s2   <= wt_s1;
	end

	// pipeline valid flags; unknown cells drop out before the sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.step && win_hit;
			v_s2 <= v_s1 && (cell_s1 != CELL_UNKNOWN);
		end
	end

	// weighted sums
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sum_v_q <= '0;
			sum_w_q <= '0;
		end else if (v_s2) begin
			sum_v_q <= sum_v_q + SUMV_W'(prod_s2);
			sum_w_q <= sum_w_q + SUMW_W'(wt_s2);
		end
	end

	// restoring divider on magnitudes, one quotient bit per cycle
	assign abs_v  = sum_v_q[SUMV_W-1] ? -sum_v_q : sum_v_q;
	assign k      = div_cnt_q - CNT_W'(1);
	assign den_sh = DIV_W'(den_q) << k;
	assign ge     = (rem_q >= den_sh);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= DIV_W'($unsigned(abs_v));
			den_q <= sum_w_q;
			neg_q <= sum_v_q[SUMV_W-1];
			quo_q <= '0;
		end else if (div_cnt_q != '0) begin
			if (ge) begin
				rem_q <= rem_q - den_sh;
			end
			quo_q <= {quo_q[QB-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= CNT_W'(QB);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= k;
		end
	end

	// signed quotient, or unknown for an outside item or an empty sum
	assign quo_s  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign result = (outside_q || (sum_w_q == '0)) ? CELL_UNKNOWN : quo_s[CELL_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			blurred_q <= result;
		end
	end

	assign blurred_value = blurred_q;

endmodule

@@ rtl/masked_gaussian_grid_blur.sv @@
// top level of the masked gaussian grid blur: configuration registers,
// controller and datapath instances, assertions; depends on mggb_pkg,
// mggb_ctrl and mggb_dp
//
// The block holds an occupancy grid (0..100 per cell, -1 unknown) in a
// single-port-read memory that is not cleared at reset: a window must only
// reach cells that were loaded. A load item inside the map is written when
// it is accepted; a load gives no result. A compute item walks its (2r+1)^2
// window one cell per cycle through the memory read port, drains a two-stage
// weight and product pipeline, then runs a restoring divider; the next item
// is taken the cycle after the result moves to the output register. A
// compute outside the map skips the walk and the divider and returns -1. The
// output register lets the next item start while a result still waits under
// out_stall. Configuration is taken at any time on the cfg channel but must
// only be written while the block is idle.

module masked_gaussian_grid_blur #(
	parameter int MAX_WIDTH  = mggb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mggb_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = mggb_pkg::DEF_MAX_RADIUS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 operation,
	input  logic [mggb_pkg::COORD_W-1:0]         row,
	input  logic [mggb_pkg::COORD_W-1:0]         col,
	input  logic signed [mggb_pkg::CELL_W-1:0]   cell_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [mggb_pkg::CELL_W-1:0]   blurred_value,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mggb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mggb_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import mggb_pkg::*;

	logic [SIZE_W-1:0]             map_width_q, map_height_q;
	logic [RADIUS_W-1:0]           kernel_radius_q;
	weight_t [NUM_WEIGHTS-1:0]     weights_q;
	mggb_cmd_t                     cmd;
	mggb_stat_t                    stat;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q     <= WIDTH_RESET;
			map_height_q    <= HEIGHT_RESET;
			kernel_radius_q <= RADIUS_RESET;
			weights_q       <= WEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAP_WIDTH:     map_width_q     <= cfg_data[SIZE_W-1:0];
				REG_MAP_HEIGHT:    map_height_q    <= cfg_data[SIZE_W-1:0];
				REG_KERNEL_RADIUS: kernel_radius_q <= cfg_data[RADIUS_W-1:0];
				REG_WEIGHT_CENTER: weights_q[0]    <= cfg_data[WEIGHT_W-1:0];
				REG_WEIGHT_ONE:    weights_q[1]    <= cfg_data[WEIGHT_W-1:0];
				REG_WEIGHT_TWO:    weights_q[2]    <= cfg_data[WEIGHT_W-1:0];
				REG_WEIGHT_THREE:  weights_q[3]    <= cfg_data[WEIGHT_W-1:0];
				REG_WEIGHT_FOUR:   weights_q[4]    <= cfg_data[WEIGHT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// controller
	mggb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.out_stall (out_stall),
		.stat      (stat),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// datapath
	mggb_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.row           (row),
		.col           (col),
		.cell_value    (cell_value),
		.map_width     (map_width_q),
		.map_height    (map_height_q),
		.kernel_radius (kernel_radius_q),
		.weights       (weights_q),
		.blurred_value (blurred_value)
	);

	// a compute item holds off the input side on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (operation == OP_COMPUTE)) |=> in_stall)
		else $error("compute item did not stall the input");

	// window pipeline only carries data while an item is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.pipe_busy |-> in_stall)
		else $error("window pipeline busy while input side is open");

	// a new result never overwrites one that is still held
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result register overwritten while stalled");

	// divider runs at least one step after it is started
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !stat.div_done)
		else $error("divider reported done right after start");

endmodule

@@ tb/masked_gaussian_grid_blur_tb.sv @@
// self-checking testbench for the masked gaussian grid blur: loads grid cells,
// requests blurred cells under several register settings and checks every result
// depends on mggb_pkg and masked_gaussian_grid_blur

module masked_gaussian_grid_blur_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mggb_pkg::*;

	localparam int HALF_PERIOD_NS     = 6;
	localparam int RESET_CYCLES       = 11;
	localparam int SETTLE_CYCLES      = 120;
	localparam int WATCHDOG_LIMIT     = 3000;
	localparam int PHASE_RANDOM_ITEMS = 55;
	localparam int REGION_SPAN        = 9;
	localparam int NUM_REGS           = 8;
	localparam int MAX_REPORTS        = 10;

	// tracks the grid and settings, predicts blurred cells and checks them in order
	class blur_scoreboard;
		logic [SIZE_W-1:0]        map_cols;
		logic [SIZE_W-1:0]        map_rows;
		logic [RADIUS_W-1:0]      radius_reg;
		weight_t                  taps [NUM_WEIGHTS];
		logic signed [CELL_W-1:0] cells [DEF_MAX_HEIGHT][DEF_MAX_WIDTH];
		bit                       loaded [DEF_MAX_HEIGHT][DEF_MAX_WIDTH];
		logic signed [CELL_W-1:0] blurred_due [$];
		int                       mismatch_count;

		function new();
			map_cols = WIDTH_RESET;
			map_rows = HEIGHT_RESET;
			radius_reg = RADIUS_RESET;
			for (int i = 0; i < NUM_WEIGHTS; i++) begin
				taps[i] = WEIGHT_RESET[i];
			end
			mismatch_count = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_MAP_WIDTH: begin
					map_cols = data[SIZE_W-1:0];
				end
				REG_MAP_HEIGHT: begin
					map_rows = data[SIZE_W-1:0];
				end
				REG_KERNEL_RADIUS: begin
					radius_reg = data[RADIUS_W-1:0];
				end
				default: begin
					taps[idx - REG_WEIGHT_CENTER] = data;
				end
			endcase
		endfunction

		// sizes in use saturate at the storage size
		function int rows_in_use();
			return (map_rows > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(map_rows);
		endfunction

		function int cols_in_use();
			return (map_cols > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(map_cols);
		endfunction

		function int reach();
			return (radius_reg > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : int'(radius_reg);
		endfunction

		// one-dimensional gain: zero past the table, capped at one
		function longint tap_gain(int d);
			if (d >= NUM_WEIGHTS) begin
				return 0;
			end
			return (taps[d] > ONE_Q16) ? longint'(ONE_Q16) : longint'(taps[d]);
		endfunction

		// true when the item is outside the map or every in-map cell of its window has been loaded
		function bit window_loaded(int row, int col);
			int h, w, r, rr, cc;
			h = rows_in_use();
			w = cols_in_use();
			r = reach();
			if (row >= h || col >= w) begin
				return 1;
			end
			for (int dm = -r; dm <= r; dm++) begin
				for (int dn = -r; dn <= r; dn++) begin
					rr = row + dm;
					cc = col + dn;
					if (rr >= 0 && rr < h && cc >= 0 && cc < w && !loaded[rr][cc]) begin
						return 0;
					end
				end
			end
			return 1;
		endfunction

		// weighted mean over the window, unknown and off-map cells skipped
		function logic signed [CELL_W-1:0] blurred_at(int row, int col);
			int h, w, r, rr, cc;
			longint acc, wsum, wt, q;
			h = rows_in_use();
			w = cols_in_use();
			r = reach();
			if (row >= h || col >= w) begin
				return CELL_UNKNOWN;
			end
			acc = 0;
			wsum = 0;
			for (int dm = -r; dm <= r; dm++) begin
				for (int dn = -r; dn <= r; dn++) begin
					rr = row + dm;
					cc = col + dn;
					if (rr < 0 || rr >= h || cc < 0 || cc >= w) begin
						continue;
					end
					if (cells[rr][cc] == CELL_UNKNOWN) begin
						continue;
					end
					wt = (tap_gain(dm < 0 ? -dm : dm) * tap_gain(dn < 0 ? -dn : dn)) >> FRAC_W;
					acc += longint'(cells[rr][cc]) * wt;
					wsum += wt;
				end
			end
			if (wsum == 0) begin
				return CELL_UNKNOWN;
			end
			q = acc / wsum;
			return q[CELL_W-1:0];
		endfunction

		function void note_item(logic op, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
			logic signed [CELL_W-1:0] val);
			if (op == OP_LOAD) begin
				if (row < rows_in_use() && col < cols_in_use()) begin
					cells[row][col] = val;
					loaded[row][col] = 1;
				end
			end else begin
				blurred_due.push_back(blurred_at(row, col));
			end
		endfunction

		function void check_result(logic signed [CELL_W-1:0] got);
			logic signed [CELL_W-1:0] want;
			if (blurred_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("unexpected blurred_value %0d, no compute outstanding", got);
				end
				return;
			end
			want = blurred_due.pop_front();
			if (got !== want) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("blurred_value wrong: expected %0d, got %0d", want, got);
				end
			end
		endfunction
	endclass

	typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_LIGHT} stall_style_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     operation = OP_LOAD;
	logic [COORD_W-1:0]       row = '0;
	logic [COORD_W-1:0]       col = '0;
	logic signed [CELL_W-1:0] cell_value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [CELL_W-1:0] blurred_value;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;

	blur_scoreboard sb = new();
	int             burst_left = 0;
	int             idle_cycles = 0;
	stall_style_t   stall_style = STALL_NONE;
	int             stall_left = 0;

	masked_gaussian_grid_blur DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.row           (row),
		.col           (col),
		.cell_value    (cell_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.blurred_value (blurred_value),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #(HALF_PERIOD_NS) clk = ~clk;
	end

	// receiver stall pattern; a new random style is picked each time the current one runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_style <= stall_style_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(8, 160);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_style)
			STALL_NONE: out_stall <= 1'b0;
			STALL_HALF: out_stall <= ($urandom_range(0, 1) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 8);
			default: out_stall <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(blurred_value);
		end
	end

	// watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// send one item, in bursts with random gaps between them
	task automatic send_item(input logic op, input int r, input int c,
		input logic signed [CELL_W-1:0] v);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 25)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		row <= COORD_W'(r);
		col <= COORD_W'(c);
		cell_value <= v;
		do @(posedge clk); while (in_stall);
		sb.note_item(op, COORD_W'(r), COORD_W'(c), v);
	endtask

	// stop sending, wait for every outstanding result, let the block settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.blurred_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all registers back to back, only while the block is idle
	task automatic apply_settings(input logic [CFG_DATA_W-1:0] vals [NUM_REGS]);
		cfg_valid <= 1'b1;
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(CFG_IDX_W'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// mostly occupancy values, some unknown, some arbitrary bytes
	function automatic logic signed [CELL_W-1:0] cell_sample();
		case ($urandom_range(0, 9))
			0, 1: return CELL_UNKNOWN;
			2: return 8'sd0;
			3: return 8'sd100;
			4: return CELL_W'($urandom_range(0, 255));
			default: return CELL_W'($urandom_range(0, 100));
		endcase
	endfunction

	// loaded region placed at a corner or anywhere in the map
	function automatic int pick_origin(input int extent, input int span);
		case ($urandom_range(0, 2))
			0: return 0;
			1: return extent - span;
			default: return $urandom_range(0, extent - span);
		endcase
	endfunction

	// random load or compute; computes only where the window is fully loaded or the item lies outside the map
	task automatic random_item(input int r0, input int c0, input int rh, input int cw);
		int  h, w, r, pick, rr, cc;
		bit  found;
		h = sb.rows_in_use();
		w = sb.cols_in_use();
		r = sb.reach();
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			if (pick < 25 && rh > 0 && cw > 0) begin
				send_item(OP_LOAD, r0 + $urandom_range(0, rh - 1), c0 + $urandom_range(0, cw - 1),
					cell_sample());
			end else begin
				send_item(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 255), cell_sample());
			end
			return;
		end
		found = 0;
		for (int k = 0; k < 8 && !found; k++) begin
			if (pick < 85 && rh > 0) begin
				rr = r0 + int'($urandom_range(0, rh - 1 + 2 * r)) - r;
				cc = c0 + int'($urandom_range(0, cw - 1 + 2 * r)) - r;
			end else begin
				rr = $urandom_range(0, 255);
				cc = $urandom_range(0, 255);
			end
			found = rr >= 0 && rr <= 255 && cc >= 0 && cc <= 255 && sb.window_loaded(rr, cc);
		end
		// fall back to a request outside the map
		if (!found && h < DEF_MAX_HEIGHT) begin
			rr = $urandom_range(h, 255);
			cc = $urandom_range(0, 255);
			found = 1;
		end else if (!found && w < DEF_MAX_WIDTH) begin
			rr = $urandom_range(0, 255);
			cc = $urandom_range(w, 255);
			found = 1;
		end
		if (found) begin
			send_item(OP_COMPUTE, rr, cc, CELL_W'($urandom_range(0, 255)));
		end else begin
			send_item(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 255), cell_sample());
		end
	endtask

	// one setting: program registers, load a region, then mixed random items
	task automatic run_phase(input int cols, input int rows, input int radius, input int w0,
		input int w1, input int w2, input int w3, input int w4, input bit random_taps);
		logic [CFG_DATA_W-1:0] vals [NUM_REGS];
		int                    h, w, rh, cw, r0, c0;
		vals[REG_MAP_WIDTH] = CFG_DATA_W'(cols);
		vals[REG_MAP_HEIGHT] = CFG_DATA_W'(rows);
		vals[REG_KERNEL_RADIUS] = CFG_DATA_W'(radius);
		vals[REG_WEIGHT_CENTER] = CFG_DATA_W'(w0);
		vals[REG_WEIGHT_ONE] = CFG_DATA_W'(w1);
		vals[REG_WEIGHT_TWO] = CFG_DATA_W'(w2);
		vals[REG_WEIGHT_THREE] = CFG_DATA_W'(w3);
		vals[REG_WEIGHT_FOUR] = CFG_DATA_W'(w4);
		if (random_taps) begin
			for (int i = REG_WEIGHT_CENTER; i <= REG_WEIGHT_FOUR; i++) begin
				vals[i] = CFG_DATA_W'($urandom_range(0, ONE_Q16));
			end
		end
		apply_settings(vals);
		h = sb.rows_in_use();
		w = sb.cols_in_use();
		rh = (h < REGION_SPAN) ? h : REGION_SPAN;
		cw = (w < REGION_SPAN) ? w : REGION_SPAN;
		r0 = pick_origin(h, rh);
		c0 = pick_origin(w, cw);
		for (int i = 0; i < rh; i++) begin
			for (int j = 0; j < cw; j++) begin
				send_item(OP_LOAD, r0 + i, c0 + j, cell_sample());
			end
		end
		repeat (PHASE_RANDOM_ITEMS) random_item(r0, c0, rh, cw);
		wait_drained();
	endtask

	initial begin
		logic signed [CELL_W-1:0] corner_vals [9];
		corner_vals = '{8'sd100, -8'sd1, 8'sd0, 8'sd127, -8'sd128, 8'sd50, -8'sd1, 8'sd1, 8'sd99};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: top-left corner with extreme values, far corner all unknown
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				send_item(OP_LOAD, i, j, corner_vals[i * 3 + j]);
				send_item(OP_LOAD, 253 + i, 253 + j, CELL_UNKNOWN);
			end
		end
		send_item(OP_COMPUTE, 0, 0, 8'sd0);
		send_item(OP_COMPUTE, 255, 255, -8'sd1);
		wait_drained();

		// register settings, extremes among them
		run_phase(8, 8, 1, 65536, 32768, 0, 0, 0, 0);
		run_phase(1, 1, 0, 65536, 57835, 39750, 21280, 8869, 0);
		run_phase(0, 5, 2, 65536, 57835, 39750, 21280, 8869, 0);
		run_phase(16, 12, 4, 65536, 57835, 39750, 21280, 8869, 0);
		run_phase(511, 511, 7, 131071, 131071, 131071, 131071, 131071, 0);
		run_phase(5, 256, 3, 0, 0, 0, 0, 0, 0);
		run_phase(256, 1, 2, 0, 65536, 0, 65536, 0, 0);
		run_phase(10, 10, 5, 0, 0, 0, 0, 0, 1);
		run_phase(300, 20, 2, 0, 0, 0, 0, 0, 1);
		run_phase(12, 9, 4, 65536, 0, 65536, 131071, 1, 0);
		run_phase(256, 256, 4, 65536, 57835, 39750, 21280, 8869, 0);
		run_phase(3, 7, 6, 0, 0, 0, 0, 0, 1);

		if (sb.mismatch_count == 0 && sb.blurred_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/mggb_pkg.sv
rtl/mggb_ctrl.sv
rtl/mggb_dp.sv
rtl/masked_gaussian_grid_blur.sv
tb/masked_gaussian_grid_blur_tb.sv
